>>> hdl/flc_pkg.sv
package flc_pkg;

  // default sizes of the filter
  localparam int unsigned TAPS_DEF        = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned COEF_BITS   = 16;
  localparam int unsigned RESULT_BITS = 40;
  localparam int unsigned TAP_CNT_W   = 5;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned IN_SMP_W    = 16;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  // register index (paddr bit 2 selects the word)
  localparam logic REG_TAP_COUNT = 1'b0;

  // input item operation
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef struct packed {
    op_e                           op;
    logic [IDX_W-1:0]              coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;
    logic signed [IN_SMP_W-1:0]    sample;
    logic                          last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_BITS-1:0] result;
    logic                          last_result;
  } out_item_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic clear;
    logic coef_we;
    logic active;
  } cell_ctrl_t;

endpackage

>>> hdl/fir_linear_convolution_core.sv
// fir linear convolution core
// input channel (in_valid_i / in_ready_o / in_data_i): each transaction either
// loads one coefficient (op load, coef_index, coef_value) or delivers one sample.
// a sample yields one result; a sample marked last_sample also yields
// (active tap count)-1 tail results while zeros shift in, the final one carries
// last_result, and the delay line is cleared for the next stream.
// output channel (out_valid_o / out_ready_i / out_data_o): one result per transaction.
// throughput: one sample per cycle while the pipeline has a free stage; the tail
// flush holds in_ready_o low until its final step, one tail step per cycle when
// the receiver keeps up, driven by the tail flush sequencer.
// a sample's product register in the tap cells loads at the accepting edge; the
// result then passes one register per level of the adder tree and then the
// output register.
// apb port: tap_count at byte address 0; user writes only while idle, unenforced by the block; pready is high.
// reset: delay line and coefficients cleared, tap_count = 1, pipeline empty.
// a stalled receiver fills the output register and then the tree levels; the
// input stays ready while any stage is free and stops once all are full.
module fir_linear_convolution_core import flc_pkg::*; #(
  parameter int unsigned TAPS        = TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  // apb configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned LEVELS = (TAPS > 1) ? $clog2(TAPS) : 0;
  localparam int unsigned LEAVES = 2 ** LEVELS;
  localparam int unsigned PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned ACC_W  = PROD_W + LEVELS + 1;
  localparam int unsigned CNT_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [31:0] TAPS_L = 32'(TAPS);

  logic [TAP_CNT_W-1:0] tap_count_q;
  logic                 flush_q;
  logic [CNT_W-1:0]     remain_q;
  logic                 p_valid_q, p_last_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  logic [31:0]                   eff_taps;
  logic                          in_fire, load_fire, sample_fire;
  logic                          s0_ready, out_en;
  logic                          step, step_last;
  logic signed [SAMPLE_BITS-1:0] in_x, step_x;
  logic                          line_zero;

  logic                          tree_in_ready, tree_valid, tree_last;
  logic signed [ACC_W-1:0]       tree_sum;
  logic signed [RESULT_BITS-1:0] sat_sum;

  cell_ctrl_t                    ctrl   [TAPS];
  logic signed [SAMPLE_BITS-1:0] tap    [TAPS];
  logic signed [SAMPLE_BITS-1:0] cell_x [TAPS];
  logic signed [PROD_W-1:0]      prod   [TAPS];
  logic signed [ACC_W-1:0]       leaf   [LEAVES];

  // apb register access
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_CNT_W'(1);
    end else if (psel && penable && pwrite && (paddr[2] == REG_TAP_COUNT)) begin
      tap_count_q <= pwdata[TAP_CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TAP_COUNT) begin
      prdata = {{(APB_DATA_W-TAP_CNT_W){1'b0}}, tap_count_q};
    end
  end

  // active tap count, clamped to 1..TAPS
  always_comb begin
    eff_taps = {{(32-TAP_CNT_W){1'b0}}, tap_count_q};
    if (tap_count_q == '0) begin
      eff_taps = 32'd1;
    end else if (eff_taps > TAPS_L) begin
      eff_taps = TAPS_L;
    end
  end

  // input handshake and step generation
  assign out_en      = !out_valid_q || out_ready_i;
  assign s0_ready    = !p_valid_q || tree_in_ready;
  assign in_ready_o  = !flush_q && s0_ready;
  assign in_fire     = in_valid_i && in_ready_o;
  assign load_fire   = in_fire && (in_data_i.op == OP_LOAD);
  assign sample_fire = in_fire && (in_data_i.op == OP_SAMPLE);
  assign step        = sample_fire || (flush_q && s0_ready);

  if (SAMPLE_BITS <= IN_SMP_W) begin : g_x_narrow
    assign in_x = in_data_i.sample[SAMPLE_BITS-1:0];
  end else begin : g_x_wide
    assign in_x = {{(SAMPLE_BITS-IN_SMP_W){1'b0}}, in_data_i.sample};
  end

  always_comb begin
    if (flush_q) begin
      step_x    = '0;
      step_last = (remain_q == CNT_W'(1));
    end else begin
      step_x    = in_x;
      step_last = in_data_i.last_sample && (eff_taps == 32'd1);
    end
  end

  // tail flush sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_q  <= 1'b0;
      remain_q <= '0;
    end else if (flush_q) begin
      if (s0_ready) begin
        remain_q <= remain_q - CNT_W'(1);
        if (remain_q == CNT_W'(1)) begin
          flush_q <= 1'b0;
        end
      end
    end else if (sample_fire && in_data_i.last_sample && (eff_taps != 32'd1)) begin
      flush_q  <= 1'b1;
      remain_q <= eff_taps[CNT_W-1:0] - CNT_W'(1);
    end
  end

  // product stage flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_last_q  <= 1'b0;
    end else if (s0_ready) begin
      p_valid_q <= step;
      p_last_q  <= step_last;
    end
  end

  // chain of tap cells
  for (genvar j = 0; j < TAPS; j++) begin : g_cell
    localparam logic [31:0] J_L = 32'(j);

    always_comb begin
      ctrl[j].shift   = step;
      ctrl[j].clear   = step_last;
      ctrl[j].coef_we = load_fire && ({{(32-IDX_W){1'b0}}, in_data_i.coef_index} == J_L);
      ctrl[j].active  = J_L < eff_taps;
    end

    if (j == 0) begin : g_head
      assign cell_x[j] = step_x;
    end else begin : g_link
      assign cell_x[j] = tap[j-1];
    end

    flc_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .HOLD_TAP    (j < TAPS - 1)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl[j]),
      .coef_i   (in_data_i.coef_value),
      .sample_i (cell_x[j]),
      .sample_o (tap[j]),
      .prod_o   (prod[j])
    );
  end

  // tree leaves, padded with zeros
  for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
    if (k < TAPS) begin : g_used
      assign leaf[k] = {{(ACC_W-PROD_W){prod[k][PROD_W-1]}}, prod[k]};
    end else begin : g_pad
      assign leaf[k] = '0;
    end
  end

  flc_tree #(
    .LEVELS (LEVELS),
    .ACC_W  (ACC_W)
  ) u_tree (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p_valid_q),
    .in_last_i   (p_last_q),
    .leaf_i      (leaf),
    .in_ready_o  (tree_in_ready),
    .out_valid_o (tree_valid),
    .out_last_o  (tree_last),
    .sum_o       (tree_sum),
    .out_ready_i (out_en)
  );

  // saturate, or sign-extend, to the result width
  if (ACC_W > RESULT_BITS) begin : g_sat
    always_comb begin
      sat_sum = tree_sum[RESULT_BITS-1:0];
      if (tree_sum[ACC_W-1:RESULT_BITS-1] != {(ACC_W-RESULT_BITS+1){1'b0}} &&
          tree_sum[ACC_W-1:RESULT_BITS-1] != {(ACC_W-RESULT_BITS+1){1'b1}}) begin
        sat_sum = tree_sum[ACC_W-1] ? {1'b1, {(RESULT_BITS-1){1'b0}}}
                                    : {1'b0, {(RESULT_BITS-1){1'b1}}};
      end
    end
  end else if (ACC_W == RESULT_BITS) begin : g_same
    assign sat_sum = tree_sum;
  end else begin : g_ext
    assign sat_sum = {{(RESULT_BITS-ACC_W){tree_sum[ACC_W-1]}}, tree_sum};
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= tree_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_q.result      <= sat_sum;
      out_q.last_result <= tree_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // delay line empty check
  always_comb begin
    line_zero = 1'b1;
    for (int j = 0; j < TAPS; j++) begin
      if (tap[j] != '0) begin
        line_zero = 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // no new transaction is taken during the tail flush
  a_flush_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> !in_ready_o)
    else $error("input accepted during tail flush");

  // the flush counter runs only while flushing
  a_remain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flush_q |-> (remain_q == '0))
    else $error("flush counter nonzero outside flush");

  // the final step of a stream leaves an empty delay line
  a_line_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && step_last) |=> line_zero)
    else $error("delay line not cleared after final step");

  // a last step ends any flush
  a_last_ends_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && step_last) |=> !flush_q)
    else $error("flush still running after final step");
`endif

endmodule

>>> hdl/flc_cell.sv
module flc_cell import flc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter bit          HOLD_TAP    = 1'b1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cell_ctrl_t                             ctrl_i,
  input  logic signed [COEF_BITS-1:0]            coef_i,
  input  logic signed [SAMPLE_BITS-1:0]          sample_i,
  output logic signed [SAMPLE_BITS-1:0]          sample_o,
  output logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod_o
);

  localparam int unsigned PROD_W = SAMPLE_BITS + COEF_BITS;

  logic signed [COEF_BITS-1:0] coef_q;
  logic signed [PROD_W-1:0]    prod_d, prod_q;

  // coefficient of this tap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (ctrl_i.coef_we) begin
      coef_q <= coef_i;
    end
  end

  // tap product, zero for taps beyond the active length
  always_comb begin
    prod_d = '0;
    if (ctrl_i.active) begin
      prod_d = coef_q * sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

  // delay element handed to the next cell
  if (HOLD_TAP) begin : g_tap
    logic signed [SAMPLE_BITS-1:0] tap_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tap_q <= '0;
      end else if (ctrl_i.shift) begin
        tap_q <= ctrl_i.clear ? '0 : sample_i;
      end
    end

    assign sample_o = tap_q;
  end else begin : g_no_tap
    assign sample_o = '0;
  end

endmodule

>>> hdl/flc_tree.sv
module flc_tree import flc_pkg::*; #(
  parameter int unsigned LEVELS = 4,
  parameter int unsigned ACC_W  = 37
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_last_i,
  input  logic signed [ACC_W-1:0] leaf_i [2**LEVELS],
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  output logic                    out_last_o,
  output logic signed [ACC_W-1:0] sum_o,
  input  logic                    out_ready_i
);

  localparam int unsigned LEAVES = 2 ** LEVELS;

  if (LEVELS == 0) begin : g_single
    // one tap: the product is the sum
    assign in_ready_o  = out_ready_i;
    assign out_valid_o = in_valid_i;
    assign out_last_o  = in_last_i;
    assign sum_o       = leaf_i[0];
  end else begin : g_tree
    // level 0 is the root, level LEVELS-1 sits next to the leaves
    logic [LEVELS-1:0]       vld_q, last_q, rdy;
    logic signed [ACC_W-1:0] node_q [1:LEAVES-1];

    // a level moves on when empty or when the level below it moves
    always_comb begin
      rdy[0] = !vld_q[0] || out_ready_i;
      for (int lv = 1; lv < LEVELS; lv++) begin
        rdy[lv] = !vld_q[lv] || rdy[lv-1];
      end
    end

    // valid and last flags per level
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q  <= '0;
        last_q <= '0;
      end else begin
        for (int lv = 0; lv < LEVELS; lv++) begin
          if (rdy[lv]) begin
            if (lv == LEVELS - 1) begin
              vld_q[lv]  <= in_valid_i;
              last_q[lv] <= in_last_i;
            end else begin
              vld_q[lv]  <= vld_q[lv+1];
              last_q[lv] <= last_q[lv+1];
            end
          end
        end
      end
    end

    // pairwise adders, one register per node
    for (genvar i = 1; i < LEAVES; i++) begin : g_node
      localparam int unsigned LV = $clog2(i + 1) - 1;
      localparam int unsigned CA = 2 * i;
      logic signed [ACC_W-1:0] a, b;

      if (CA >= LEAVES) begin : g_from_leaf
        assign a = leaf_i[CA-LEAVES];
        assign b = leaf_i[CA+1-LEAVES];
      end else begin : g_from_node
        assign a = node_q[CA];
        assign b = node_q[CA+1];
      end

      always_ff @(posedge clk_i) begin
        if (rdy[LV]) begin
          node_q[i] <= a + b;
        end
      end
    end

    assign in_ready_o  = rdy[LEVELS-1];
    assign out_valid_o = vld_q[0];
    assign out_last_o  = last_q[0];
    assign sum_o       = node_q[1];
  end

endmodule
